FILE: hw/rtl/tpr_pkg.sv
package tpr_pkg;

	localparam int unsigned CNT_W   = 3;
	localparam int unsigned WIN_W   = 8;
	localparam int unsigned COORD_W = 16;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [7:0]         HDR_FIRST  = 8'hA1;
	localparam logic [7:0]         HDR_SECOND = 8'h00;
	localparam logic [CNT_W-1:0]   PKT_LAST   = 3'd5;
	localparam logic [COORD_W-1:0] IN_FULL    = 16'hFFFF;
	localparam logic [WIN_W-1:0]   WIN_MAX    = 8'hFF;

	localparam logic [WIN_W-1:0]   WINDOW_MS_RST  = 8'd30;
	localparam logic [COORD_W-1:0] FULL_SCALE_RST = 16'd10000;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 1'd1;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} rx_item_t;

	typedef struct packed {
		logic               pressed;
		logic [COORD_W-1:0] coord_x;
		logic [COORD_W-1:0] coord_y;
	} ev_item_t;

endpackage

FILE: hw/rtl/tpr_scale.sv
module tpr_scale (
	input  logic                          clk,
	input  logic                          en,
	input  logic [tpr_pkg::COORD_W-1:0]   value,
	input  logic [tpr_pkg::COORD_W-1:0]   scale,
	output logic [tpr_pkg::COORD_W-1:0]   quot
);

	logic [2*tpr_pkg::COORD_W-1:0] prod_s2;
	logic [2*tpr_pkg::COORD_W:0]   sum;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= (2*tpr_pkg::COORD_W)'(value) * (2*tpr_pkg::COORD_W)'(scale);
		end
	end

	// floor(p / 65535) = (p + (p >> 16) + 1) >> 16 for any product of two 16-bit values
	assign sum = (2*tpr_pkg::COORD_W+1)'(prod_s2)
		+ (2*tpr_pkg::COORD_W+1)'(prod_s2[2*tpr_pkg::COORD_W-1:tpr_pkg::COORD_W])
		+ (2*tpr_pkg::COORD_W+1)'(1);
	assign quot = sum[2*tpr_pkg::COORD_W-1:tpr_pkg::COORD_W];

endmodule

FILE: hw/rtl/touch_packet_receiver_core.sv
// Channel | Direction | Handshake              | Payload
// rx      | in        | rx_valid / rx_stall    | rx_item (kind, data_byte)
// ev      | out       | ev_valid / ev_stall    | ev_item (pressed, coord_x, coord_y)
// cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item per cycle while ev is not stalled. Behind the input register, the packet state
// update and coordinate multiply are registered in stage 2, then the divide by 65535 into ev.
// Items that produce no event leave the pipe after the state update stage.
// arst_n clears all control state and loads the register reset values.
// A stalled ev holds its result while the two stages behind it keep filling.
module touch_packet_receiver_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                rx_valid,
	output logic                                rx_stall,
	input  tpr_pkg::rx_item_t                   rx_item,
	output logic                                ev_valid,
	input  logic                                ev_stall,
	output tpr_pkg::ev_item_t                   ev_item,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tpr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tpr_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic [tpr_pkg::WIN_W-1:0]   window_ms_q;
	logic [tpr_pkg::COORD_W-1:0] full_scale_q;

	logic [tpr_pkg::CNT_W-1:0] cnt_q, cnt_nx;
	logic [tpr_pkg::WIN_W-1:0] elapsed_q, elapsed_nx, elapsed_inc;
	logic                      held_q, held_nx;
	logic [7:0]                x_hi_q, x_lo_q, y_hi_q;

	logic                      valid_s1;
	tpr_pkg::rx_item_t         item_s1;
	logic                      valid_s2;
	logic                      pressed_s2;
	logic                      ev_valid_q;
	tpr_pkg::ev_item_t         ev_item_q;

	logic ev_free, s2_free, s1_free, fire;
	logic emit, press;
	logic [tpr_pkg::COORD_W-1:0] x_val, y_val, x_quot, y_quot;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_ms_q  <= tpr_pkg::WINDOW_MS_RST;
			full_scale_q <= tpr_pkg::FULL_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tpr_pkg::REG_WINDOW_MS:  window_ms_q  <= cfg_data[tpr_pkg::WIN_W-1:0];
				tpr_pkg::REG_FULL_SCALE: full_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ev_free  = !ev_valid_q || !ev_stall;
	assign s2_free  = !valid_s2 || ev_free;
	assign s1_free  = !valid_s1 || s2_free;
	assign rx_stall = !s1_free;
	assign fire     = valid_s1 && s2_free;

	assign elapsed_inc = (elapsed_q == tpr_pkg::WIN_MAX) ? elapsed_q
		: elapsed_q + tpr_pkg::WIN_W'(1);

	always_comb begin
		cnt_nx     = cnt_q;
		elapsed_nx = elapsed_q;
		held_nx    = held_q;
		emit       = 1'b0;
		press      = 1'b0;
		if (item_s1.kind == tpr_pkg::KIND_TICK) begin
			elapsed_nx = elapsed_inc;
			if (elapsed_inc >= window_ms_q) begin
				// window expired: drop partial packet, release if a touch is held
				elapsed_nx = '0;
				cnt_nx     = '0;
				if (held_q) begin
					held_nx = 1'b0;
					emit    = 1'b1;
				end
			end
		end else begin
			case (cnt_q)
				3'd0: cnt_nx = (item_s1.data_byte == tpr_pkg::HDR_FIRST) ? 3'd1 : 3'd0;
				3'd1: cnt_nx = (item_s1.data_byte == tpr_pkg::HDR_SECOND) ? 3'd2 : 3'd0;
				3'd2, 3'd3, 3'd4: cnt_nx = cnt_q + 3'd1;
				tpr_pkg::PKT_LAST: begin
					cnt_nx     = '0;
					elapsed_nx = '0;
					held_nx    = 1'b1;
					emit       = 1'b1;
					press      = 1'b1;
				end
				default: cnt_nx = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			elapsed_q <= '0;
			held_q    <= 1'b0;
		end else if (fire) begin
			cnt_q     <= cnt_nx;
			elapsed_q <= elapsed_nx;
			held_q    <= held_nx;
		end
	end

	// payload bytes; the last Y byte is used straight from the input register
	always_ff @(posedge clk) begin
		if (fire && item_s1.kind == tpr_pkg::KIND_BYTE) begin
			case (cnt_q)
				3'd2: x_hi_q <= item_s1.data_byte;
				3'd3: x_lo_q <= item_s1.data_byte;
				3'd4: y_hi_q <= item_s1.data_byte;
				default: ;
			endcase
		end
	end

	assign x_val = press ? {x_hi_q, x_lo_q} : '0;
	assign y_val = press ? tpr_pkg::IN_FULL - {y_hi_q, item_s1.data_byte} : '0;

	tpr_scale u_scale_x (
		.clk   (clk),
		.en    (fire && s2_free),
		.value (x_val),
		.scale (full_scale_q),
		.quot  (x_quot)
	);

	tpr_scale u_scale_y (
		.clk   (clk),
		.en    (fire && s2_free),
		.value (y_val),
		.scale (full_scale_q),
		.quot  (y_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			ev_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= rx_valid;
			end
			if (s2_free) begin
				valid_s2 <= fire && emit;
			end
			if (ev_free) begin
				ev_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && rx_valid) begin
			item_s1 <= rx_item;
		end
		if (fire) begin
			pressed_s2 <= press;
		end
		if (ev_free && valid_s2) begin
			ev_item_q.pressed <= pressed_s2;
			ev_item_q.coord_x <= x_quot;
			ev_item_q.coord_y <= y_quot;
		end
	end

	assign ev_valid = ev_valid_q;
	assign ev_item  = ev_item_q;

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= tpr_pkg::PKT_LAST)
		else $error("packet byte count out of range");

	a_release_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && !ev_item.pressed |-> ev_item.coord_x == '0 && ev_item.coord_y == '0)
		else $error("release event carries nonzero coordinates");

	a_press_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && press |=> held_q && cnt_q == '0 && elapsed_q == '0)
		else $error("completed packet did not set held state");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> valid_s1 && valid_s2 && ev_valid_q)
		else $error("input stalled with room in the pipeline");
`endif

endmodule

FILE: verif/touch_packet_receiver_core_tb.sv
module touch_packet_receiver_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STALL_PCT       = 37;
	localparam int unsigned HOLD_CYCLES     = 300;
	localparam int unsigned IDLE_LIMIT      = 5000;
	localparam int unsigned DRAIN_CYCLES    = 8;
	localparam int unsigned PHASES          = 10;
	localparam int unsigned ITEMS_PER_PHASE = 113;
	localparam int unsigned DIRECTED_ITEMS  = 22;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           rx_valid  = 1'b0;
	logic                           rx_stall;
	tpr_pkg::rx_item_t              rx_item   = '0;
	logic                           ev_valid;
	logic                           ev_stall  = 1'b0;
	tpr_pkg::ev_item_t              ev_item;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [tpr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [tpr_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	tpr_pkg::rx_item_t pending_rx[$];
	tpr_pkg::ev_item_t touch_events[$];
	int unsigned errors      = 0;
	int unsigned queued      = 0;
	bit          no_gaps     = 1'b0;
	int unsigned hold_reqs   = 0;
	int unsigned hold_seen   = 0;
	int unsigned hold_left   = 0;
	int unsigned idle_cycles = 0;

	// mirror of the receiver state and its registers
	logic [tpr_pkg::CNT_W-1:0]   pkt_count  = '0;
	logic [7:0]                  pkt_bytes [4];
	logic [tpr_pkg::WIN_W-1:0]   win_ticks  = '0;
	logic                        touch_down = 1'b0;
	logic [tpr_pkg::WIN_W-1:0]   cur_window = tpr_pkg::WINDOW_MS_RST;
	logic [tpr_pkg::COORD_W-1:0] cur_scale  = tpr_pkg::FULL_SCALE_RST;

	touch_packet_receiver_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx_item   (rx_item),
		.ev_valid  (ev_valid),
		.ev_stall  (ev_stall),
		.ev_item   (ev_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [tpr_pkg::COORD_W-1:0] scale_coord(
		logic [tpr_pkg::COORD_W-1:0] v);
		logic [31:0] prod;
		prod = 32'(v) * 32'(cur_scale);
		return tpr_pkg::COORD_W'(prod / 32'(tpr_pkg::IN_FULL));
	endfunction

	function void predict_touch(tpr_pkg::rx_item_t it);
		tpr_pkg::ev_item_t ev;
		if (it.kind == tpr_pkg::KIND_TICK) begin
			if (win_ticks != tpr_pkg::WIN_MAX)
				win_ticks = win_ticks + tpr_pkg::WIN_W'(1);
			if (win_ticks >= cur_window) begin
				win_ticks = '0;
				pkt_count = '0;
				if (touch_down) begin
					touch_down = 1'b0;
					ev = '0;
					touch_events.push_back(ev);
				end
			end
			return;
		end
		if ((pkt_count == 0 && it.data_byte != tpr_pkg::HDR_FIRST) ||
				(pkt_count == 1 && it.data_byte != tpr_pkg::HDR_SECOND)) begin
			pkt_count = '0;
			return;
		end
		if (pkt_count >= 2)
			pkt_bytes[2'(pkt_count - 3'd2)] = it.data_byte;
		if (pkt_count == tpr_pkg::PKT_LAST) begin
			pkt_count  = '0;
			win_ticks  = '0;
			touch_down = 1'b1;
			ev.pressed = 1'b1;
			ev.coord_x = scale_coord({pkt_bytes[0], pkt_bytes[1]});
			ev.coord_y = scale_coord(tpr_pkg::IN_FULL - {pkt_bytes[2], pkt_bytes[3]});
			touch_events.push_back(ev);
		end else begin
			pkt_count = pkt_count + 3'd1;
		end
	endfunction

	function void check_event(tpr_pkg::ev_item_t got);
		tpr_pkg::ev_item_t want;
		if (touch_events.size() == 0) begin
			$error("unexpected event: pressed=%0d coord_x=%0d coord_y=%0d",
				got.pressed, got.coord_x, got.coord_y);
			errors++;
			return;
		end
		want = touch_events.pop_front();
		if (got.pressed !== want.pressed) begin
			$error("pressed: expected %0d, actual %0d", want.pressed, got.pressed);
			errors++;
		end
		if (got.coord_x !== want.coord_x) begin
			$error("coord_x: expected %0d, actual %0d", want.coord_x, got.coord_x);
			errors++;
		end
		if (got.coord_y !== want.coord_y) begin
			$error("coord_y: expected %0d, actual %0d", want.coord_y, got.coord_y);
			errors++;
		end
	endfunction

	// driver: hold the payload while stalled, advance after each transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid <= 1'b0;
		end else begin
			if (rx_valid && !rx_stall)
				predict_touch(rx_item);
			if (!rx_valid || !rx_stall) begin
				if (pending_rx.size() != 0 && (no_gaps || $urandom_range(99) >= STALL_PCT)) begin
					rx_valid <= 1'b1;
					rx_item  <= pending_rx.pop_front();
				end else begin
					rx_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each event, stall at random or for a long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_stall <= 1'b0;
		end else begin
			if (ev_valid && !ev_stall)
				check_event(ev_item);
			if (hold_seen != hold_reqs) begin
				hold_seen <= hold_reqs;
				hold_left <= HOLD_CYCLES;
				ev_stall  <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				ev_stall  <= 1'b1;
			end else begin
				ev_stall <= !no_gaps && ($urandom_range(99) < STALL_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_valid && !rx_stall) || (ev_valid && !ev_stall) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic push_byte(logic [7:0] b);
		tpr_pkg::rx_item_t it;
		it.kind      = tpr_pkg::KIND_BYTE;
		it.data_byte = b;
		pending_rx.push_back(it);
		queued++;
	endtask

	task automatic push_tick();
		tpr_pkg::rx_item_t it;
		it.kind      = tpr_pkg::KIND_TICK;
		it.data_byte = 8'($urandom_range(255));
		pending_rx.push_back(it);
		queued++;
	endtask

	task automatic push_packet(logic [15:0] x, logic [15:0] y);
		push_byte(tpr_pkg::HDR_FIRST);
		push_byte(tpr_pkg::HDR_SECOND);
		push_byte(x[15:8]);
		push_byte(x[7:0]);
		push_byte(y[15:8]);
		push_byte(y[7:0]);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(4))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic maybe_tick();
		if ($urandom_range(9) == 0)
			push_tick();
	endtask

	task automatic queue_random_op();
		int unsigned       r;
		int unsigned       n;
		tpr_pkg::rx_item_t it;
		r = $urandom_range(99);
		if (r < 60) begin
			push_byte(tpr_pkg::HDR_FIRST);
			maybe_tick();
			push_byte(tpr_pkg::HDR_SECOND);
			repeat (4) begin
				maybe_tick();
				push_byte(pick_byte());
			end
		end else if (r < 75) begin
			n = $urandom_range(1, (cur_window > 30) ? 64 : cur_window + 3);
			repeat (n) push_tick();
		end else if (r < 88) begin
			// broken header or truncated packet
			push_byte(tpr_pkg::HDR_FIRST);
			if ($urandom_range(1)) begin
				push_byte(8'($urandom_range(1, 255)));
			end else begin
				push_byte(tpr_pkg::HDR_SECOND);
				n = $urandom_range(0, 3);
				repeat (n) push_byte(pick_byte());
			end
		end else begin
			it = tpr_pkg::rx_item_t'(9'($urandom_range(511)));
			pending_rx.push_back(it);
			queued++;
		end
	endtask

	task automatic cfg_write(logic [tpr_pkg::CFG_IDX_W-1:0] idx,
		logic [tpr_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == tpr_pkg::REG_WINDOW_MS)
			cur_window = val[tpr_pkg::WIN_W-1:0];
		else
			cur_scale = val;
	endtask

	// wait until every event has come, then let tick/byte items leave the pipe
	task automatic wait_drained();
		do @(negedge clk); while (pending_rx.size() != 0 || rx_valid || touch_events.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		int unsigned               ph;
		logic [tpr_pkg::WIN_W-1:0] w;
		logic [15:0]               s;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_packet(16'h0000, 16'h0000);
		push_tick();
		push_byte(8'h55);
		push_byte(tpr_pkg::HDR_FIRST);
		push_byte(8'h7F);
		push_packet(16'hFFFF, 16'hFFFF);
		push_packet(16'h8000, 16'h7FFF);

		for (ph = 0; ph < PHASES; ph++) begin
			if (ph != 0) begin
				wait_drained();
				case (ph)
					1: begin
						w = 8'd1;
						s = 16'hFFFF;
					end
					2: begin
						w = tpr_pkg::WIN_MAX;
						s = 16'd1;
					end
					3: begin
						w = 8'd0;
						s = 16'd0;
					end
					default: begin
						w = 8'($urandom_range(1, 40));
						s = 16'($urandom_range(1, 65535));
					end
				endcase
				cfg_write(tpr_pkg::REG_WINDOW_MS, {8'd0, w});
				cfg_write(tpr_pkg::REG_FULL_SCALE, s);
				@(negedge clk);
				no_gaps = (ph == 5);
				if (ph == 4)
					hold_reqs++;
				// run the widest window out so the tick count reaches its maximum and expires
				if (ph == 2)
					repeat (tpr_pkg::WIN_MAX + 5) push_tick();
			end
			while (queued < DIRECTED_ITEMS + ITEMS_PER_PHASE * (ph + 1))
				queue_random_op();
		end

		wait_drained();
		repeat (20) @(negedge clk);
		if (errors == 0 && touch_events.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: touch_packet_receiver_core.f
hw/rtl/tpr_pkg.sv
hw/rtl/tpr_scale.sv
hw/rtl/touch_packet_receiver_core.sv
verif/touch_packet_receiver_core_tb.sv
